// File: rtl/csr_mapping_inverse_unit_macros.svh
// Assertion macros shared by the csr mapping inverse unit.
`ifndef CSR_MAPPING_INVERSE_UNIT_MACROS_SVH
`define CSR_MAPPING_INVERSE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CMI_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: invariant violated");
`define CMI_ASSERT_NEXT(label, cause, effect) \
  label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("%m: sequence violated");
`else
`define CMI_ASSERT_ALWAYS(label, expr)
`define CMI_ASSERT_NEXT(label, cause, effect)
`endif

`endif

// File: rtl/cmi_pkg.sv
// Shared types and constants of the csr mapping inverse unit.
`timescale 1ns / 1ps

package cmi_pkg;

  localparam int CMP_W = 18;

  localparam logic [2:0] KIND_CLEAR  = 3'd0;
  localparam logic [2:0] KIND_LOAD   = 3'd1;
  localparam logic [2:0] KIND_BUILD  = 3'd2;
  localparam logic [2:0] KIND_RD_OFS = 3'd3;
  localparam logic [2:0] KIND_RD_INV = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_RANGE   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ADDR    = 3'd3;
  localparam logic [2:0] ST_UNBUILT = 3'd4;

  localparam logic [8:0] TC_RESET = 9'd256;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_OFS, S_RD_INV, S_CLR,
    S_CNT_A, S_CNT_B, S_CNT_C,
    S_PRE_A, S_PRE_B,
    S_SCT_A, S_SCT_B, S_SCT_C,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {OUT_ZERO, OUT_OFS, OUT_INV} out_src_t;

  typedef struct packed {
    logic       load_elem;
    logic       clear_all;
    logic       build_start;
    logic       build_done;
    logic       i_rst;
    logic       i_inc;
    logic       j_rst;
    logic       j_inc;
    logic       clr_wr;
    logic       cnt_rd;
    logic       cnt_wr;
    logic       pre_rd;
    logic       pre_wr;
    logic       sct_wr;
    logic       out_load;
    out_src_t   out_src;
    logic [2:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic tgt_ok;
    logic full;
    logic built;
    logic ofs_ok;
    logic inv_ok;
    logic i_end;
    logic j_end;
    logic t_live;
  } stat_t;

endpackage

// File: rtl/cmi_if.sv
// Channel interfaces of the csr mapping inverse unit.
`timescale 1ns / 1ps

interface cmi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  target_index;
  logic [9:0]  source_row;
  logic [10:0] read_address;

  modport source (output valid, kind, target_index, source_row, read_address, input ready);
  modport sink (input valid, kind, target_index, source_row, read_address, output ready);
endinterface

interface cmi_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] value;
  logic [2:0]  status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

interface cmi_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/cmi_ctrl.sv
// Controller state machine: transaction decode and build sequencing.
`timescale 1ns / 1ps

module cmi_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic [2:0]     req_kind,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  cmi_pkg::stat_t stat,
  output cmi_pkg::cmd_t  cmd
);

  cmi_pkg::state_t state;
  cmi_pkg::state_t state_next;
  logic            accept;

  assign req_ready = (state == cmi_pkg::S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cmi_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= cmd.out_load || (rsp_valid && !rsp_ready);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      cmi_pkg::S_IDLE: begin
        if (accept) begin
          case (req_kind)
            cmi_pkg::KIND_BUILD: state_next = cmi_pkg::S_CLR;
            cmi_pkg::KIND_RD_OFS: begin
              if (stat.built && stat.ofs_ok) state_next = cmi_pkg::S_RD_OFS;
            end
            cmi_pkg::KIND_RD_INV: begin
              if (stat.built && stat.inv_ok) state_next = cmi_pkg::S_RD_INV;
            end
            default: state_next = cmi_pkg::S_IDLE;
          endcase
        end
      end
      cmi_pkg::S_RD_OFS: state_next = cmi_pkg::S_IDLE;
      cmi_pkg::S_RD_INV: state_next = cmi_pkg::S_IDLE;
      cmi_pkg::S_CLR: begin
        if (stat.j_end) state_next = cmi_pkg::S_CNT_A;
      end
      cmi_pkg::S_CNT_A: state_next = stat.i_end ? cmi_pkg::S_PRE_A : cmi_pkg::S_CNT_B;
      cmi_pkg::S_CNT_B: state_next = stat.t_live ? cmi_pkg::S_CNT_C : cmi_pkg::S_CNT_A;
      cmi_pkg::S_CNT_C: state_next = cmi_pkg::S_CNT_A;
      cmi_pkg::S_PRE_A: state_next = stat.j_end ? cmi_pkg::S_SCT_A : cmi_pkg::S_PRE_B;
      cmi_pkg::S_PRE_B: state_next = cmi_pkg::S_PRE_A;
      cmi_pkg::S_SCT_A: state_next = stat.i_end ? cmi_pkg::S_DONE : cmi_pkg::S_SCT_B;
      cmi_pkg::S_SCT_B: state_next = stat.t_live ? cmi_pkg::S_SCT_C : cmi_pkg::S_SCT_A;
      cmi_pkg::S_SCT_C: state_next = cmi_pkg::S_SCT_A;
      cmi_pkg::S_DONE:  state_next = cmi_pkg::S_IDLE;
      default:          state_next = cmi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_src    = cmi_pkg::OUT_ZERO;
    cmd.out_status = cmi_pkg::ST_OK;
    case (state)
      cmi_pkg::S_IDLE: begin
        if (accept) begin
          case (req_kind)
            cmi_pkg::KIND_CLEAR: begin
              cmd.clear_all = 1'b1;
              cmd.out_load  = 1'b1;
            end
            cmi_pkg::KIND_LOAD: begin
              cmd.out_load = 1'b1;
              if (!stat.tgt_ok) begin
                cmd.out_status = cmi_pkg::ST_RANGE;
              end else if (stat.full) begin
                cmd.out_status = cmi_pkg::ST_FULL;
              end else begin
                cmd.load_elem = 1'b1;
              end
            end
            cmi_pkg::KIND_BUILD: begin
              cmd.build_start = 1'b1;
              cmd.j_rst       = 1'b1;
            end
            cmi_pkg::KIND_RD_OFS: begin
              if (!stat.built) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = cmi_pkg::ST_UNBUILT;
              end else if (!stat.ofs_ok) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = cmi_pkg::ST_ADDR;
              end
            end
            cmi_pkg::KIND_RD_INV: begin
              if (!stat.built) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = cmi_pkg::ST_UNBUILT;
              end else if (!stat.inv_ok) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = cmi_pkg::ST_ADDR;
              end
            end
            default: cmd.out_load = 1'b1;
          endcase
        end
      end
      cmi_pkg::S_RD_OFS: begin
        cmd.out_load = 1'b1;
        cmd.out_src  = cmi_pkg::OUT_OFS;
      end
      cmi_pkg::S_RD_INV: begin
        cmd.out_load = 1'b1;
        cmd.out_src  = cmi_pkg::OUT_INV;
      end
      cmi_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.j_end) cmd.i_rst = 1'b1;
        else cmd.j_inc = 1'b1;
      end
      cmi_pkg::S_CNT_A: begin
        if (stat.i_end) cmd.j_rst = 1'b1;
      end
      cmi_pkg::S_CNT_B: begin
        if (stat.t_live) cmd.cnt_rd = 1'b1;
        else cmd.i_inc = 1'b1;
      end
      cmi_pkg::S_CNT_C: begin
        cmd.cnt_wr = 1'b1;
        cmd.i_inc  = 1'b1;
      end
      cmi_pkg::S_PRE_A: begin
        if (stat.j_end) cmd.i_rst = 1'b1;
        else cmd.pre_rd = 1'b1;
      end
      cmi_pkg::S_PRE_B: begin
        cmd.pre_wr = 1'b1;
        cmd.j_inc  = 1'b1;
      end
      cmi_pkg::S_SCT_B: begin
        if (!stat.t_live) cmd.i_inc = 1'b1;
      end
      cmi_pkg::S_SCT_C: begin
        cmd.sct_wr = 1'b1;
        cmd.i_inc  = 1'b1;
      end
      cmi_pkg::S_DONE: begin
        cmd.build_done = 1'b1;
        cmd.out_load   = 1'b1;
      end
      default: cmd.out_load = 1'b0;
    endcase
  end

endmodule

// File: rtl/cmi_datapath.sv
// Datapath: element store, offset table, write positions and inverse data.
`timescale 1ns / 1ps

module cmi_datapath #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_TARGETS  = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  cmi_pkg::cmd_t  cmd,
  output cmi_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic [8:0]     cfg_data,
  input  logic [7:0]     target_index,
  input  logic [9:0]     source_row,
  input  logic [10:0]    read_address,
  output logic [10:0]    value,
  output logic [2:0]     status
);

  localparam int EAW = $clog2(MAX_ELEMENTS);
  localparam int CW  = $clog2(MAX_ELEMENTS + 1);
  localparam int TW  = $clog2(MAX_TARGETS);
  localparam int TAW = $clog2(MAX_TARGETS + 1);
  localparam int XW  = cmi_pkg::CMP_W;

  logic [8:0]     tc;
  logic [TAW-1:0] tcb;
  logic [CW-1:0]  cnt;
  logic           built;
  logic [TAW-1:0] built_targets;
  logic [CW-1:0]  built_total;
  logic [CW-1:0]  i;
  logic [TAW-1:0] j;
  logic [CW-1:0]  run;

  logic [7:0]  elem_tgt [MAX_ELEMENTS];
  logic [9:0]  elem_row [MAX_ELEMENTS];
  logic [CW-1:0] ofs_mem [MAX_TARGETS + 1];
  logic [CW-1:0] wpos_mem [MAX_TARGETS];
  logic [9:0]  inv_mem [MAX_ELEMENTS];

  logic [7:0]    et_q;
  logic [9:0]    er_q;
  logic [CW-1:0] ofs_q;
  logic [CW-1:0] wp_q;
  logic [9:0]    inv_q;

  logic [XW-1:0]  live_x;
  logic [XW-1:0]  tc_x;
  logic [XW-1:0]  addr_x;
  logic [XW-1:0]  t_x;
  logic [XW-1:0]  tp1_x;
  logic [XW-1:0]  ofs_x;
  logic [TAW-1:0] jp1;
  logic           ofs_we;
  logic [TAW-1:0] ofs_wa;
  logic [TAW-1:0] ofs_ra;
  logic [CW-1:0]  ofs_wd;
  logic           wp_we;
  logic [TW-1:0]  wp_wa;
  logic [CW-1:0]  wp_wd;

  assign tc_x   = XW'(tc);
  assign live_x = (tc_x < XW'(MAX_TARGETS)) ? tc_x : XW'(MAX_TARGETS);
  assign addr_x = XW'(read_address);
  assign t_x    = XW'(et_q);
  assign tp1_x  = t_x + XW'(1);
  assign ofs_x  = XW'(ofs_q);
  assign jp1    = j + TAW'(1);

  assign stat.tgt_ok = XW'(target_index) < live_x;
  assign stat.full   = XW'(cnt) == XW'(MAX_ELEMENTS);
  assign stat.built  = built;
  assign stat.ofs_ok = addr_x <= XW'(built_targets);
  assign stat.inv_ok = addr_x < XW'(built_total);
  assign stat.i_end  = i == cnt;
  assign stat.j_end  = j == tcb;
  assign stat.t_live = t_x < XW'(tcb);

  always_ff @(posedge clk) begin
    if (rst) begin
      tc            <= cmi_pkg::TC_RESET;
      cnt           <= '0;
      built         <= 1'b0;
      built_targets <= '0;
      built_total   <= '0;
    end else begin
      if (cfg_we) tc <= cfg_data;
      if (cmd.clear_all) begin
        cnt   <= '0;
        built <= 1'b0;
      end else if (cmd.load_elem) begin
        cnt   <= cnt + CW'(1);
        built <= 1'b0;
      end else if (cmd.build_done) begin
        built         <= 1'b1;
        built_targets <= tcb;
        built_total   <= run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_start) begin
      tcb <= live_x[TAW-1:0];
      run <= '0;
    end else if (cmd.pre_wr) begin
      run <= run + ofs_q;
    end
    if (cmd.i_rst) i <= '0;
    else if (cmd.i_inc) i <= i + CW'(1);
    if (cmd.j_rst) j <= '0;
    else if (cmd.j_inc) j <= jp1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_elem) begin
      elem_tgt[cnt[EAW-1:0]] <= target_index;
      elem_row[cnt[EAW-1:0]] <= source_row;
    end
    et_q <= elem_tgt[i[EAW-1:0]];
    er_q <= elem_row[i[EAW-1:0]];
  end

  always_comb begin
    ofs_we = cmd.clr_wr || cmd.cnt_wr || cmd.pre_wr;
    if (cmd.clr_wr) begin
      ofs_wa = j;
      ofs_wd = '0;
    end else if (cmd.cnt_wr) begin
      ofs_wa = tp1_x[TAW-1:0];
      ofs_wd = ofs_q + CW'(1);
    end else begin
      ofs_wa = jp1;
      ofs_wd = run + ofs_q;
    end
    if (cmd.pre_rd) ofs_ra = jp1;
    else if (cmd.cnt_rd) ofs_ra = tp1_x[TAW-1:0];
    else ofs_ra = addr_x[TAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ofs_we) ofs_mem[ofs_wa] <= ofs_wd;
    ofs_q <= ofs_mem[ofs_ra];
  end

  always_comb begin
    wp_we = cmd.pre_wr || cmd.sct_wr;
    if (cmd.pre_wr) begin
      wp_wa = j[TW-1:0];
      wp_wd = run;
    end else begin
      wp_wa = t_x[TW-1:0];
      wp_wd = wp_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wp_we) wpos_mem[wp_wa] <= wp_wd;
    wp_q <= wpos_mem[t_x[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.sct_wr) inv_mem[wp_q[EAW-1:0]] <= er_q;
    inv_q <= inv_mem[addr_x[EAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      case (cmd.out_src)
        cmi_pkg::OUT_OFS: value <= ofs_x[10:0];
        cmi_pkg::OUT_INV: value <= {1'b0, inv_q};
        default:          value <= '0;
      endcase
    end
  end

endmodule

// File: rtl/csr_mapping_inverse_unit.sv
// Top level of the csr mapping inverse unit (CSR transpose by counting sort).
//
//   Channel  Dir  Payload                                          Transaction
//   req      in   kind, target_index, source_row, read_address     valid & ready
//   rsp      out  value, status                                    valid & ready
//   cfg      in   data (target_count)                              valid & ready
//
// Clear, load, unused kinds and rejected reads load the output register on acceptance;
// accepted reads go through a read state first, as the offset or inverse memory has a
// registered read port. A build clears the offset table, counts the N stored elements
// per target, forms prefix offsets over the T targets in effect, scatters the elements
// to their places and then finishes; each memory has a single read and write port pair.
// Reset is synchronous and clears control state; no clearing pass.
// req is held off while a result waits in the output register and is not taken.
`timescale 1ns / 1ps
`include "csr_mapping_inverse_unit_macros.svh"

module csr_mapping_inverse_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_TARGETS  = 256
) (
  input logic       clk,
  input logic       rst,
  cmi_in_if.sink    req,
  cmi_out_if.source rsp,
  cmi_cfg_if.sink   cfg
);

  cmi_pkg::cmd_t  cmd;
  cmi_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  cmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cmi_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_TARGETS  (MAX_TARGETS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_data     (cfg.data),
    .target_index (req.target_index),
    .source_row   (req.source_row),
    .read_address (req.read_address),
    .value        (rsp.value),
    .status       (rsp.status)
  );

  `CMI_ASSERT_ALWAYS(a_no_result_overwrite, !(cmd.out_load && rsp.valid && !rsp.ready))
  `CMI_ASSERT_ALWAYS(a_ofs_single_writer, $onehot0({cmd.clr_wr, cmd.cnt_wr, cmd.pre_wr}))
  `CMI_ASSERT_ALWAYS(a_no_load_when_full, !(cmd.load_elem && stat.full))
  `CMI_ASSERT_NEXT(a_build_stalls_input, cmd.build_start, !req.ready)
  `CMI_ASSERT_NEXT(a_built_after_build, cmd.build_done, stat.built)

endmodule
